// ----- rtl/core/four_level_page_table_walker_macros.svh -----
// Assertion macros for the page table walker.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FLPTW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define FLPTW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/flptw_pkg.sv -----
// Types and constants shared by the page table walker.
`default_nettype none

package flptw_pkg;

	localparam int TABLE_PAGES_DEF   = 16;
	localparam int ENTRIES_PER_TABLE = 512;
	localparam int IDX_W             = 9;
	localparam int DESC_W            = 64;
	localparam int VA_W              = 64;
	localparam int EIDX_W            = 13;
	localparam int FRAME_W           = 48;
	localparam int FRAME_LO          = 12;
	localparam int FRAME_BITS        = 36;
	localparam int STATUS_W          = 3;
	localparam int COUNT_W           = 2;
	localparam int OP_W              = 2;
	localparam int ROOT_W            = 4;
	localparam int IN_DATA_W         = 144;
	localparam int OUT_DATA_W        = 56;
	localparam int CFG_IDX_W         = 2;
	localparam int CFG_DATA_W        = 4;

	localparam logic [FRAME_W-1:0] FRAME_MASK = 48'hFFFF_FFFF_F000;

	localparam logic [OP_W-1:0] OP_WRITE     = 2'd0;
	localparam logic [OP_W-1:0] OP_TRANSLATE = 2'd1;
	localparam logic [OP_W-1:0] OP_UNMAP     = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_L0_MISS = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_L1_MISS = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_L2_MISS = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_L3_MISS = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROOT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_USER_ROOT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_USER_EN     = 2'd2;

	localparam logic [1:0] LVL_0 = 2'd0;
	localparam logic [1:0] LVL_1 = 2'd1;
	localparam logic [1:0] LVL_2 = 2'd2;
	localparam logic [1:0] LVL_3 = 2'd3;

	typedef enum logic [6:0] {
		ST_CLEAR  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_ISSUE  = 7'b0000100,
		ST_LOOK   = 7'b0001000,
		ST_REDUCE = 7'b0010000,
		ST_WZERO  = 7'b0100000,
		ST_RESP   = 7'b1000000
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/core/four_level_page_table_walker.sv -----
// Four-level page table walker over an internal descriptor store.
//
//  channel  dir  handshake                       payload
//  s_axis   in   s_axis_tvalid / s_axis_tready   op, virt_addr, entry_index, entry_data
//  m_axis   out  m_axis_tvalid / m_axis_tready   phys_frame, status, cleared_count
//  cfg      in   cfg_valid / cfg_ready           cfg_index, cfg_data
//
// Write: straight to the response. Translate: one descriptor read per level, up to four.
// Unmap: per walk (kernel, then user when enabled) up to 3 reads and 1 clear.
// Each descriptor read is a store access (ISSUE) followed by a decode (LOOK); for a
// TABLE_PAGES that is not a power of two the next-page reduction adds a REDUCE state a level.
// After reset the store is cleared one word a cycle (TABLE_PAGES*512 words);
// s_axis_tready stays low meanwhile, cfg writes are always taken.
// A finished result waits in the output register while the next beat is accepted.
`default_nettype none
`include "four_level_page_table_walker_macros.svh"

module four_level_page_table_walker
	import flptw_pkg::*;
#(
	parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// operation[1:0], virt_addr[65:2], entry_index[78:66], entry_data[142:79]
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// phys_frame[47:0], status[50:48], cleared_count[52:51]
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int PAGE_W      = $clog2(TABLE_PAGES);
	localparam int ADDR_W      = PAGE_W + IDX_W;
	localparam int STORE_WORDS = TABLE_PAGES * ENTRIES_PER_TABLE;
	localparam int RW          = PAGE_W + 2;
	localparam int SUM_W       = PAGE_W + 4;
	localparam int RED_DIGITS  = FRAME_BITS / 4;
	localparam bit PAGES_POW2  = (TABLE_PAGES & (TABLE_PAGES - 1)) == 0;
	localparam logic [RW-1:0]   PAGES_RW   = RW'(TABLE_PAGES);
	localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(STORE_WORDS - 1);

	// small page number (4 bits) mod TABLE_PAGES, at most three subtractions
	function automatic logic [PAGE_W-1:0] page_of4(input logic [ROOT_W-1:0] v);
		logic [RW-1:0] r;
		r = RW'(v);
		for (int i = 0; i < 3; i++) begin
			if (r >= PAGES_RW) begin
				r = r - PAGES_RW;
			end
		end
		return r[PAGE_W-1:0];
	endfunction

	// weight of each hex digit value at each digit position, mod TABLE_PAGES
	function automatic logic [RED_DIGITS*16*PAGE_W-1:0] red_table();
		logic [RED_DIGITS*16*PAGE_W-1:0] t;
		logic [63:0]                     w;
		t = '0;
		for (int j = 0; j < RED_DIGITS; j++) begin
			w = (64'd1 << (4 * j)) % 64'(TABLE_PAGES);
			for (int d = 0; d < 16; d++) begin
				t[PAGE_W * (16 * j + d) +: PAGE_W] = PAGE_W'((64'(d) * w) % 64'(TABLE_PAGES));
			end
		end
		return t;
	endfunction

	localparam logic [RED_DIGITS*16*PAGE_W-1:0] RED_TBL = red_table();

	logic [DESC_W-1:0]     store_q [STORE_WORDS];
	logic [DESC_W-1:0]     rd_data_q;

	state_t                state_q;
	logic [ADDR_W-1:0]     clr_cnt_q;
	logic [OP_W-1:0]       op_q;
	logic [VA_W-1:0]       va_q;
	logic [1:0]            lvl_q;
	logic [PAGE_W-1:0]     page_q;
	logic                  phase_q;
	logic [FRAME_W-1:0]    frame_q;
	logic [STATUS_W-1:0]   status_q;
	logic [COUNT_W-1:0]    count_q;
	logic [FRAME_BITS-1:0] red_val_q;
	logic [SUM_W-1:0]      red_sum_q;
	logic                  red_ph_q;
	logic [ROOT_W-1:0]     kroot_q;
	logic [ROOT_W-1:0]     uroot_q;
	logic                  uen_q;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic [OP_W-1:0]       in_op;
	logic [VA_W-1:0]       in_va;
	logic [EIDX_W-1:0]     in_eidx;
	logic [DESC_W-1:0]     in_edata;
	logic                  in_beat;
	logic [IDX_W-1:0]      lvl_idx;
	logic [ADDR_W-1:0]     rd_addr;
	logic                  rd_en;
	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;
	logic [DESC_W-1:0]     wr_data;
	logic [SUM_W-1:0]      red_sum;
	logic [SUM_W-1:0]      red_acc;
	logic [PAGE_W-1:0]     red_nxt;
	logic                  out_free;

	assign in_op    = s_axis_tdata[1:0];
	assign in_va    = s_axis_tdata[65:2];
	assign in_eidx  = s_axis_tdata[78:66];
	assign in_edata = s_axis_tdata[142:79];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign out_free      = !out_valid_q || m_axis_tready;

	always_comb begin
		case (lvl_q)
			LVL_0: lvl_idx = va_q[47:39];
			LVL_1: lvl_idx = va_q[38:30];
			LVL_2: lvl_idx = va_q[29:21];
			default: lvl_idx = va_q[20:12];
		endcase
	end

	assign rd_addr = {page_q, lvl_idx};
	assign rd_en   = (state_q == ST_ISSUE);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_cnt_q;
		wr_data = '0;
		case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
			end
			ST_IDLE: begin
				wr_en   = in_beat && (in_op == OP_WRITE);
				wr_addr = {page_of4(in_eidx[12:9]), in_eidx[8:0]};
				wr_data = in_edata;
			end
			ST_WZERO: begin
				wr_en   = 1'b1;
				wr_addr = rd_addr;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// next-page mod TABLE_PAGES: sum of digit weights, then compare and subtract
	always_comb begin
		red_sum = '0;
		for (int j = 0; j < RED_DIGITS; j++) begin
			red_sum = red_sum +
				SUM_W'(RED_TBL[PAGE_W * (16 * j + int'(red_val_q[4 * j +: 4])) +: PAGE_W]);
		end
		red_acc = red_sum_q;
		for (int k = 3; k >= 0; k--) begin
			if (red_acc >= (SUM_W'(TABLE_PAGES) << k)) begin
				red_acc = red_acc - (SUM_W'(TABLE_PAGES) << k);
			end
		end
		red_nxt = red_acc[PAGE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= store_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kroot_q <= '0;
			uroot_q <= '0;
			uen_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_KERNEL_ROOT: kroot_q <= cfg_data;
				CFG_USER_ROOT:   uroot_q <= cfg_data;
				CFG_USER_EN:     uen_q   <= cfg_data[0];
				default:         uen_q   <= uen_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			op_q        <= '0;
			va_q        <= '0;
			lvl_q       <= LVL_0;
			page_q      <= '0;
			phase_q     <= 1'b0;
			frame_q     <= '0;
			status_q    <= STAT_OK;
			count_q     <= '0;
			red_val_q   <= '0;
			red_sum_q   <= '0;
			red_ph_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (m_axis_tready && state_q != ST_RESP) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == LAST_WORD) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_beat) begin
						op_q     <= in_op;
						va_q     <= in_va;
						lvl_q    <= LVL_0;
						phase_q  <= 1'b0;
						frame_q  <= '0;
						status_q <= STAT_OK;
						count_q  <= '0;
						if (in_op == OP_TRANSLATE) begin
							page_q  <= (uen_q && in_va[63:48] == '0) ? page_of4(uroot_q)
							                                         : page_of4(kroot_q);
							state_q <= ST_ISSUE;
						end else if (in_op == OP_UNMAP) begin
							page_q  <= page_of4(kroot_q);
							state_q <= ST_ISSUE;
						end else begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_ISSUE: begin
					state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					if (!rd_data_q[0]) begin
						if (op_q == OP_TRANSLATE) begin
							case (lvl_q)
								LVL_0: status_q <= STAT_L0_MISS;
								LVL_1: status_q <= STAT_L1_MISS;
								LVL_2: status_q <= STAT_L2_MISS;
								default: status_q <= STAT_L3_MISS;
							endcase
							state_q <= ST_RESP;
						end else if (!phase_q && uen_q) begin
							phase_q <= 1'b1;
							lvl_q   <= LVL_0;
							page_q  <= page_of4(uroot_q);
							state_q <= ST_ISSUE;
						end else begin
							state_q <= ST_RESP;
						end
					end else if (lvl_q == LVL_3) begin
						frame_q <= rd_data_q[FRAME_W-1:0] & FRAME_MASK;
						state_q <= ST_RESP;
					end else if (lvl_q == LVL_2 && !rd_data_q[1]) begin
						if (op_q == OP_TRANSLATE) begin
							frame_q <= rd_data_q[FRAME_W-1:0] & FRAME_MASK;
							state_q <= ST_RESP;
						end else begin
							state_q <= ST_WZERO;
						end
					end else begin
						lvl_q <= lvl_q + 2'd1;
						if (PAGES_POW2) begin
							page_q  <= rd_data_q[FRAME_LO +: PAGE_W];
							state_q <= (op_q == OP_UNMAP && lvl_q == LVL_2) ? ST_WZERO : ST_ISSUE;
						end else begin
							red_val_q <= rd_data_q[FRAME_LO +: FRAME_BITS];
							red_ph_q  <= 1'b0;
							state_q   <= ST_REDUCE;
						end
					end
				end
				ST_REDUCE: begin
					if (!red_ph_q) begin
						red_sum_q <= red_sum;
						red_ph_q  <= 1'b1;
					end else begin
						page_q  <= red_nxt;
						state_q <= (op_q == OP_UNMAP && lvl_q == LVL_3) ? ST_WZERO : ST_ISSUE;
					end
				end
				ST_WZERO: begin
					count_q <= count_q + 1'b1;
					if (!phase_q && uen_q) begin
						phase_q <= 1'b1;
						lvl_q   <= LVL_0;
						page_q  <= page_of4(uroot_q);
						state_q <= ST_ISSUE;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {3'b000, count_q, status_q, frame_q};
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`FLPTW_ASSERT_NOW(a_port_excl, rd_en, !wr_en, "store read and write in one cycle")
	`FLPTW_ASSERT_NOW(a_clear_block, state_q == ST_CLEAR, !s_axis_tready, "beat taken during clear")
	`FLPTW_ASSERT_NEXT(a_beat_busy, in_beat, state_q != ST_IDLE, "idle right after a beat")
	`FLPTW_ASSERT_NOW(a_l3_read, state_q == ST_LOOK && lvl_q == LVL_3, op_q == OP_TRANSLATE, "unmap at l3")
	`FLPTW_ASSERT_NOW(a_wzero_lvl, state_q == ST_WZERO, op_q == OP_UNMAP && lvl_q[1], "bad clear")

endmodule

`default_nettype wire

// ----- tb/sv/walk_checker.sv -----
// Page table walker checker: predicts each walk result and compares the result beats.
`timescale 1ns / 1ps

module walk_checker
	import flptw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);

	localparam int PAGES  = TABLE_PAGES_DEF;
	localparam int WORDS  = PAGES * ENTRIES_PER_TABLE;
	localparam int WORD_W = $clog2(WORDS);

	typedef struct packed {
		logic [FRAME_W-1:0]  frame;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  cleared;
	} walk_result_t;

	logic [DESC_W-1:0] desc_mem [WORDS];
	logic [ROOT_W-1:0] kern_root;
	logic [ROOT_W-1:0] user_root;
	logic              user_en;
	walk_result_t      expected_walks [$];

	function automatic logic [WORD_W-1:0] word_of(input int unsigned page,
			input logic [VA_W-1:0] va, input int shift);
		return WORD_W'((page % PAGES) * ENTRIES_PER_TABLE + int'(va[shift +: IDX_W]));
	endfunction

	function automatic int unsigned next_page(input logic [DESC_W-1:0] desc);
		return int'(desc[FRAME_LO +: FRAME_BITS] % PAGES);
	endfunction

	// walks one table and zeroes the final entry; 1 when the walk got that far
	function automatic logic clear_leaf(input int unsigned root, input logic [VA_W-1:0] va);
		logic [DESC_W-1:0] d;
		logic [WORD_W-1:0] a;
		d = desc_mem[word_of(root, va, 39)];
		if (!d[0])
			return 1'b0;
		d = desc_mem[word_of(next_page(d), va, 30)];
		if (!d[0])
			return 1'b0;
		a = word_of(next_page(d), va, 21);
		d = desc_mem[a];
		if (!d[0])
			return 1'b0;
		if (!d[1])
			desc_mem[a] = '0;
		else
			desc_mem[word_of(next_page(d), va, 12)] = '0;
		return 1'b1;
	endfunction

	function automatic walk_result_t predict_walk(input logic [OP_W-1:0] op,
			input logic [VA_W-1:0] va, input logic [EIDX_W-1:0] eidx,
			input logic [DESC_W-1:0] edata);
		walk_result_t      r;
		logic [DESC_W-1:0] d;
		int unsigned       root;
		r = '0;
		case (op)
			OP_WRITE: begin
				desc_mem[WORD_W'(eidx % WORDS)] = edata;
			end
			OP_TRANSLATE: begin
				root = (user_en && va[63:48] == '0) ? user_root : kern_root;
				d = desc_mem[word_of(root, va, 39)];
				if (!d[0]) begin
					r.status = STAT_L0_MISS;
				end else begin
					d = desc_mem[word_of(next_page(d), va, 30)];
					if (!d[0]) begin
						r.status = STAT_L1_MISS;
					end else begin
						d = desc_mem[word_of(next_page(d), va, 21)];
						if (!d[0]) begin
							r.status = STAT_L2_MISS;
						end else if (!d[1]) begin
							r.frame = d[FRAME_W-1:0] & FRAME_MASK;
						end else begin
							d = desc_mem[word_of(next_page(d), va, 12)];
							if (!d[0])
								r.status = STAT_L3_MISS;
							else
								r.frame = d[FRAME_W-1:0] & FRAME_MASK;
						end
					end
				end
			end
			OP_UNMAP: begin
				r.cleared = {1'b0, clear_leaf(kern_root, va)};
				if (user_en)
					r.cleared = r.cleared + clear_leaf(user_root, va);
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		walk_result_t got;
		walk_result_t want;
		if (!arst_n) begin
			foreach (desc_mem[i])
				desc_mem[i] = '0;
			kern_root = '0;
			user_root = '0;
			user_en = 1'b0;
			fail_count = 0;
			expected_walks.delete();
			pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.frame = m_axis_tdata[0 +: FRAME_W];
				got.status = m_axis_tdata[FRAME_W +: STATUS_W];
				got.cleared = m_axis_tdata[FRAME_W + STATUS_W +: COUNT_W];
				if (expected_walks.size() == 0) begin
					$display("%0t: result beat with nothing expected, expected none, actual %h",
						$time, got);
					fail_count++;
				end else begin
					want = expected_walks.pop_front();
					check_field("phys_frame", 64'(want.frame), 64'(got.frame));
					check_field("status", 64'(want.status), 64'(got.status));
					check_field("cleared_count", 64'(want.cleared), 64'(got.cleared));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_KERNEL_ROOT: kern_root = cfg_data[ROOT_W-1:0];
					CFG_USER_ROOT:   user_root = cfg_data[ROOT_W-1:0];
					CFG_USER_EN:     user_en = cfg_data[0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_walks.push_back(predict_walk(s_axis_tdata[1:0], s_axis_tdata[65:2],
					s_axis_tdata[78:66], s_axis_tdata[142:79]));
			pending <= expected_walks.size();
		end
	end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the page table walker testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
	import flptw_pkg::*;

	localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
	localparam int              RUN_LIMIT   = 500000;
	localparam int              HOLD_CYCLES = 400;
	localparam logic [63:0]     VA_USER     = 64'h0000_FFFF_FFFF_F000;
	localparam logic [63:0]     VA_KERN     = 64'hFFFF_FFFF_FFFF_F000;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int   fail_count;
	int   pending;
	int   idle_pct = 0;
	int   stall_pct = 0;
	int   items_done = 0;
	int   cycle_cnt = 0;
	int   hold_left = 0;
	logic hold_tog = 1'b0;
	logic hold_seen = 1'b0;
	int   cur_k;
	int   cur_u;
	logic cur_en;

	four_level_page_table_walker u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	walk_checker u_walk_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == RUN_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_tog != hold_seen) begin
			hold_seen <= hold_tog;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	// random descriptor with the given type bits and next-table page
	function automatic logic [63:0] desc_with(input logic [1:0] kind, input int page);
		logic [63:0] d;
		d = rnd64();
		d[1:0] = kind;
		d[15:12] = 4'(page);
		return d;
	endfunction

	task automatic send(input logic [OP_W-1:0] op, input logic [63:0] va,
			input logic [EIDX_W-1:0] idx, input logic [63:0] data);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, data, idx, va, op};
		do @(posedge clk); while (!s_axis_tready);
		if (op != OP_RESERVED)
			items_done++;
	endtask

	task automatic write_desc(input logic [EIDX_W-1:0] idx, input logic [63:0] data);
		send(OP_WRITE, rnd64(), idx, data);
	endtask

	task automatic translate(input logic [63:0] va);
		send(OP_TRANSLATE, va, 13'($urandom), rnd64());
	endtask

	task automatic unmap(input logic [63:0] va);
		send(OP_UNMAP, va, 13'($urandom), rnd64());
	endtask

	// builds the chain for va under root; brk names a level written invalid (4: none)
	task automatic map_va(input int root, input logic [63:0] va, input int p1, input int p2,
			input int p3, input bit as_block, input int brk);
		logic [1:0] lax;
		lax = {1'($urandom), 1'b1};
		write_desc({4'(root), va[47:39]}, desc_with(brk == 0 ? 2'b00 : lax, p1));
		if (brk == 0)
			return;
		lax = {1'($urandom), 1'b1};
		write_desc({4'(p1), va[38:30]}, desc_with(brk == 1 ? 2'b10 : lax, p2));
		if (brk == 1)
			return;
		if (brk == 2)
			write_desc({4'(p2), va[29:21]}, desc_with(2'b10, p3));
		else if (as_block)
			write_desc({4'(p2), va[29:21]}, desc_with(2'b01, p3));
		else
			write_desc({4'(p2), va[29:21]}, desc_with(2'b11, p3));
		if (brk == 2 || as_block)
			return;
		write_desc({4'(p3), va[20:12]},
			desc_with({1'($urandom), brk == 3 ? 1'b0 : 1'b1}, $urandom_range(0, 15)));
	endtask

	task automatic set_roots(input int k, input int u, input logic en);
		logic [CFG_IDX_W-1:0]  ids  [3];
		logic [CFG_DATA_W-1:0] vals [3];
		ids = '{CFG_KERNEL_ROOT, CFG_USER_ROOT, CFG_USER_EN};
		vals = '{4'(k), 4'(u), {3'($urandom), en}};
		cur_k = k;
		cur_u = u;
		cur_en = en;
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= ids[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	initial begin
		int          settings [8][3];
		int          target;
		int          root;
		int          pick;
		int          brk;
		logic [63:0] va;
		settings = '{'{15, 0, 1}, '{0, 15, 0}, '{5, 5, 1}, '{15, 15, 0},
			'{0, 0, 1}, '{3, 12, 1}, '{9, 2, 1}, '{15, 15, 1}};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_roots(0, 1, 1'b1);

		translate(VA_USER);
		send(OP_RESERVED, '1, '1, '1);
		write_desc('1, '1);
		write_desc('0, '0);
		map_va(1, VA_USER, 2, 3, 4, 1'b0, 4);
		translate(VA_USER);
		translate(VA_USER | 64'hFFF);
		map_va(0, VA_KERN, 5, 6, 0, 1'b1, 4);
		translate(VA_KERN);
		unmap(VA_KERN);
		translate(VA_KERN);
		translate(VA_USER);
		unmap(VA_USER);
		translate(64'h0000_0080_0000_0000);
		map_va(1, 64'h0000_0100_0000_0000, 7, 8, 9, 1'b0, 1);
		translate(64'h0000_0100_0000_0000);
		drain();

		target = items_done;
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 5)
				set_roots($urandom_range(0, 15), $urandom_range(0, 15), 1'($urandom));
			else
				set_roots(settings[ph][0], settings[ph][1], settings[ph][2][0]);
			case (ph / 2)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 68; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 68; end
				default: begin idle_pct = 33; stall_pct = 33; end
			endcase
			if (ph == 1)
				hold_tog <= ~hold_tog;
			target += 66;
			while (items_done < target) begin
				va = rnd64();
				if ($urandom_range(0, 3) != 0)
					va[63:48] = '0;
				root = (cur_en && va[63:48] == '0) ? cur_u : cur_k;
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					brk = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 4;
					map_va(root, va, $urandom_range(0, 15), $urandom_range(0, 15),
						$urandom_range(0, 15), 1'($urandom), brk);
					translate(va);
					if ($urandom_range(0, 1))
						translate({va[63:12], 12'($urandom)});
					if ($urandom_range(0, 2) == 0) begin
						if (cur_en)
							map_va(cur_k, va, $urandom_range(0, 15), $urandom_range(0, 15),
								$urandom_range(0, 15), 1'($urandom), 4);
						unmap(va);
						translate(va);
					end
				end else if (pick < 80) begin
					if ($urandom_range(0, 1))
						translate(va);
					else
						unmap(va);
				end else if (pick < 95) begin
					write_desc(13'($urandom), rnd64());
				end else begin
					send(OP_RESERVED, rnd64(), 13'($urandom), rnd64());
				end
			end
			drain();
		end

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
